[rtl/png_scanline_unfilter_defines.svh]
// Assertion macros for the PNG scanline unfilter checker.
// No dependencies; included by the files that assert.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PSU_ASSERT_IMPLY(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("png_scanline_unfilter: port check failed");

// Next-cycle implication, disabled while reset is high.
`define PSU_ASSERT_NEXT(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("png_scanline_unfilter: port check failed");

`endif

[rtl/psu_pkg.sv]
// Shared types, codes and helpers of the PNG scanline unfilter.
// No dependencies; used by the interfaces, front end, queue, back end, top level and bench.
`default_nettype none

package psu_pkg;

   localparam int DATA_W      = 8;
   localparam int CSR_PIXEL_W = 4;
   localparam int CSR_LINE_W  = 14;
   localparam int CSR_DATA_W  = 14;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_LINE  = 2'd1;

   // Window slot; wide enough for the largest pixel size of eight bytes
   localparam int SLOT_W = 3;

   localparam logic [DATA_W-1:0] FILTER_MAX_CODE = 8'd4;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      FILTER_NONE    = 3'd0,
      FILTER_SUB     = 3'd1,
      FILTER_UP      = 3'd2,
      FILTER_AVERAGE = 3'd3,
      FILTER_PAETH   = 3'd4,
      FILTER_BAD     = 3'd5
   } filter_code_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      filter_code_type   filter;
      logic [SLOT_W-1:0] slot;
      logic              first_row;
      logic              line_start;
      logic              line_end;
   } op_type;

   function automatic logic [DATA_W-1:0] paeth_predict(
      input logic [DATA_W-1:0] a,
      input logic [DATA_W-1:0] b,
      input logic [DATA_W-1:0] c
   );
      logic signed [DATA_W+1:0] sa;
      logic signed [DATA_W+1:0] sb;
      logic signed [DATA_W+1:0] sc;
      logic signed [DATA_W+1:0] da;
      logic signed [DATA_W+1:0] db;
      logic signed [DATA_W+1:0] dc;
      logic signed [DATA_W+1:0] pa;
      logic signed [DATA_W+1:0] pb;
      logic signed [DATA_W+1:0] pc;
      logic [DATA_W-1:0]        pick;
      sa = $signed({2'b00, a});
      sb = $signed({2'b00, b});
      sc = $signed({2'b00, c});
      // p - a = b - c, p - b = a - c, p - c = a + b - 2c
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = (da < 0) ? -da : da;
      pb = (db < 0) ? -db : db;
      pc = (dc < 0) ? -dc : dc;
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

`default_nettype wire

[rtl/psu_req_if.sv]
// Input channel of the PNG scanline unfilter: one stream byte per word.
// Depends on psu_pkg.
`default_nettype none

interface psu_req_if;
   logic                      valid;
   logic                      ready;
   logic [psu_pkg::DATA_W-1:0] data_byte;
   logic                      new_image;

   modport source(output valid, output data_byte, output new_image, input ready);
   modport sink(input valid, input data_byte, input new_image, output ready);
endinterface

`default_nettype wire

[rtl/psu_rsp_if.sv]
// Result channel of the PNG scanline unfilter: one raw byte per word.
// Depends on psu_pkg.
`default_nettype none

interface psu_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [psu_pkg::DATA_W-1:0] pixel_byte;
   logic                      line_end;
   logic                      bad_filter;

   modport source(output valid, output pixel_byte, output line_end, output bad_filter,
                  input ready);
   modport sink(input valid, input pixel_byte, input line_end, input bad_filter,
                output ready);
endinterface

`default_nettype wire

[rtl/psu_front.sv]
// Front end: configuration registers, filter type capture, line position and
// window slot tracking; emits one op per sample byte. Depends on psu_pkg, psu_req_if.
`default_nettype none

module psu_front #(
   parameter int MAX_LINE_BYTES  = 8192,
   parameter int MAX_PIXEL_BYTES = 8,
   localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [psu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [psu_pkg::CSR_DATA_W-1:0]    csr_write_data,
   psu_req_if.sink                                req_if,
   input  wire logic                              q_ready,
   output logic                                   q_push,
   output psu_pkg::op_type                        q_op,
   output logic [POS_W-1:0]                       q_pos
);

   localparam int LEN_W     = $clog2(MAX_LINE_BYTES + 1);
   localparam int CMP_W     = (LEN_W > psu_pkg::CSR_LINE_W) ? LEN_W : psu_pkg::CSR_LINE_W;
   localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam logic [PIX_IDX_W-1:0] PIX_LAST = PIX_IDX_W'(MAX_PIXEL_BYTES - 1);
   localparam logic [CMP_W-1:0]     LEN_MAX  = CMP_W'(MAX_LINE_BYTES);

   logic [psu_pkg::CSR_PIXEL_W-1:0] bpp_ff, bpp_in;
   logic [psu_pkg::CSR_LINE_W-1:0]  len_ff, len_in;
   logic                            awaiting_ff, awaiting_in;
   logic                            first_row_ff, first_row_in;
   psu_pkg::filter_code_type        filter_ff, filter_in;
   logic [POS_W-1:0]                pos_ff, pos_in;
   logic [psu_pkg::SLOT_W-1:0]      slot_cnt_ff [MAX_PIXEL_BYTES];
   logic [psu_pkg::SLOT_W-1:0]      slot_cnt_in [MAX_PIXEL_BYTES];

   logic                            accept;
   logic                            awaiting_now;
   logic                            first_row_now;
   logic [psu_pkg::CSR_PIXEL_W-1:0] bpp_m1;
   logic [PIX_IDX_W-1:0]            pix_idx;
   logic [CMP_W-1:0]                len_ext;
   logic [CMP_W-1:0]                len_eff;
   logic [CMP_W-1:0]                pos_inc;
   logic                            line_done;

   assign req_if.ready = q_ready;

   always_comb begin
      bpp_in = bpp_ff;
      len_in = len_ff;
      if (csr_write_enable) begin
         case (csr_index)
            psu_pkg::CSR_BYTES_PER_PIXEL: bpp_in = csr_write_data[psu_pkg::CSR_PIXEL_W-1:0];
            psu_pkg::CSR_BYTES_PER_LINE:  len_in = csr_write_data[psu_pkg::CSR_LINE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      accept        = req_if.valid && q_ready;
      awaiting_now  = awaiting_ff || req_if.new_image;
      first_row_now = first_row_ff || req_if.new_image;

      // zero acts as one, oversize saturates
      bpp_m1 = bpp_ff - 1'b1;
      if (bpp_ff == '0) begin
         pix_idx = '0;
      end else if (bpp_ff > MAX_PIXEL_BYTES) begin
         pix_idx = PIX_LAST;
      end else begin
         pix_idx = bpp_m1[PIX_IDX_W-1:0];
      end

      len_ext = CMP_W'(len_ff);
      if (len_ext == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_ext > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = len_ext;
      end
      pos_inc   = CMP_W'(pos_ff) + 1'b1;
      line_done = (pos_inc >= len_eff);

      q_push           = accept && !awaiting_now;
      q_pos            = pos_ff;
      q_op.data_byte   = req_if.data_byte;
      q_op.filter      = filter_ff;
      q_op.slot        = slot_cnt_ff[pix_idx];
      q_op.first_row   = first_row_now;
      q_op.line_start  = (pos_ff == '0);
      q_op.line_end    = line_done;

      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      filter_in    = filter_ff;
      pos_in       = pos_ff;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         slot_cnt_in[k] = slot_cnt_ff[k];
      end

      if (accept) begin
         first_row_in = first_row_now;
         if (awaiting_now) begin
            // filter type byte: start a fresh line
            filter_in   = (req_if.data_byte > psu_pkg::FILTER_MAX_CODE)
                          ? psu_pkg::FILTER_BAD
                          : psu_pkg::filter_code_type'(req_if.data_byte[2:0]);
            pos_in      = '0;
            awaiting_in = 1'b0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               slot_cnt_in[k] = '0;
            end
         end else begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               slot_cnt_in[k] = (slot_cnt_ff[k] == psu_pkg::SLOT_W'(k))
                                ? '0 : slot_cnt_ff[k] + 1'b1;
            end
            if (line_done) begin
               pos_in       = '0;
               awaiting_in  = 1'b1;
               first_row_in = 1'b0;
            end else begin
               pos_in = pos_inc[POS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= psu_pkg::CSR_PIXEL_W'(1);
         len_ff       <= psu_pkg::CSR_LINE_W'(1);
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
         filter_ff    <= psu_pkg::FILTER_NONE;
         pos_ff       <= '0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            slot_cnt_ff[k] <= '0;
         end
      end else begin
         bpp_ff       <= bpp_in;
         len_ff       <= len_in;
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
         filter_ff    <= filter_in;
         pos_ff       <= pos_in;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            slot_cnt_ff[k] <= slot_cnt_in[k];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/psu_queue.sv]
// Short op queue between the front end and the reconstruction back end.
// Depends on psu_pkg.
`default_nettype none

module psu_queue #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  ready,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int DEPTH = psu_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      ready      = (count_ff != CNT_FULL);
      head_valid = (count_ff != '0);
      head_data  = entry_ff[rd_ptr_ff];
      do_push    = push && ready;
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/psu_back.sv]
// Back end: line store, left and upper-left windows, predictor and result
// register. Depends on psu_pkg, psu_rsp_if.
`default_nettype none

module psu_back #(
   parameter int MAX_LINE_BYTES  = 8192,
   parameter int MAX_PIXEL_BYTES = 8,
   localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  psu_pkg::op_type       head_op,
   input  wire logic [POS_W-1:0] head_pos,
   output logic                  pop,
   psu_rsp_if.source             rsp_if
);

   localparam int LEN_W     = $clog2(MAX_LINE_BYTES + 1);
   localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int DW        = psu_pkg::DATA_W;

   logic [DW-1:0] line_mem [MAX_LINE_BYTES];
   logic [DW-1:0] mem_rdata_ff;

   logic [DW-1:0]              left_ff   [MAX_PIXEL_BYTES];
   logic [DW-1:0]              upleft_ff [MAX_PIXEL_BYTES];
   logic [MAX_PIXEL_BYTES-1:0] win_valid_ff, win_valid_in;
   logic [LEN_W-1:0]           fill_ff, fill_in;

   logic                b1_valid_ff, b1_valid_in;
   psu_pkg::op_type     b1_op_ff, b1_op_in;
   logic [POS_W-1:0]    b1_pos_ff, b1_pos_in;
   logic                fwd_ff, fwd_in;
   logic [DW-1:0]       fwd_data_ff, fwd_data_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]       rsp_byte_ff, rsp_byte_in;
   logic                rsp_end_ff, rsp_end_in;
   logic                rsp_bad_ff, rsp_bad_in;

   logic                       advance;
   logic                       load;
   logic [PIX_IDX_W-1:0]       slot;
   logic [MAX_PIXEL_BYTES-1:0] valid_now;
   logic [MAX_PIXEL_BYTES-1:0] slot_mask;
   logic [DW-1:0]              a;
   logic [DW-1:0]              b;
   logic [DW-1:0]              c;
   logic [DW:0]                avg_sum;
   logic [DW-1:0]              pred;
   logic [DW-1:0]              x;
   logic [LEN_W-1:0]           pos_inc;
   logic                       above_known;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_byte = rsp_byte_ff;
   assign rsp_if.line_end   = rsp_end_ff;
   assign rsp_if.bad_filter = rsp_bad_ff;

   always_comb begin
      advance = b1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
      load    = head_valid && (!b1_valid_ff || advance);
      pop     = load;

      slot = b1_op_ff.slot[PIX_IDX_W-1:0];
      // a new line sees an empty window
      valid_now = b1_op_ff.line_start ? '0 : win_valid_ff;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         slot_mask[k] = (slot == PIX_IDX_W'(k));
      end
      a = valid_now[slot] ? left_ff[slot] : '0;
      c = valid_now[slot] ? upleft_ff[slot] : '0;

      // positions past the fill mark were never written and read as zero
      above_known = !b1_op_ff.first_row && (LEN_W'(b1_pos_ff) < fill_ff);
      b = above_known ? (fwd_ff ? fwd_data_ff : mem_rdata_ff) : '0;

      avg_sum = {1'b0, a} + {1'b0, b};
      case (b1_op_ff.filter)
         psu_pkg::FILTER_NONE:    pred = '0;
         psu_pkg::FILTER_SUB:     pred = a;
         psu_pkg::FILTER_UP:      pred = b;
         psu_pkg::FILTER_AVERAGE: pred = avg_sum[DW:1];
         psu_pkg::FILTER_PAETH:   pred = psu_pkg::paeth_predict(a, b, c);
         default:                 pred = '0;
      endcase
      x = b1_op_ff.data_byte + pred;

      pos_inc = LEN_W'(b1_pos_ff) + 1'b1;
      fill_in = (advance && pos_inc > fill_ff) ? pos_inc : fill_ff;
      win_valid_in = advance ? (valid_now | slot_mask) : win_valid_ff;

      b1_valid_in = load ? 1'b1 : (advance ? 1'b0 : b1_valid_ff);
      b1_op_in    = load ? head_op : b1_op_ff;
      b1_pos_in   = load ? head_pos : b1_pos_ff;
      // the store read misses a write landing on the same address this edge
      fwd_in      = load ? (advance && (b1_pos_ff == head_pos)) : fwd_ff;
      fwd_data_in = load ? x : fwd_data_ff;

      rsp_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
      rsp_byte_in  = advance ? x : rsp_byte_ff;
      rsp_end_in   = advance ? b1_op_ff.line_end : rsp_end_ff;
      rsp_bad_in   = advance ? (b1_op_ff.filter == psu_pkg::FILTER_BAD) : rsp_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_valid_ff <= '0;
         fill_ff      <= '0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         win_valid_ff <= win_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_op_ff    <= b1_op_in;
      b1_pos_ff   <= b1_pos_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_bad_ff  <= rsp_bad_in;
      if (advance) begin
         left_ff[slot]   <= x;
         upleft_ff[slot] <= b;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mem_rdata_ff <= line_mem[head_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         line_mem[b1_pos_ff] <= x;
      end
   end

endmodule

`default_nettype wire

[rtl/png_scanline_unfilter.sv]
// PNG scanline unfilter (filter method 0). Takes one inflated stream byte per
// word on req_if; the first byte of each line is the filter type and gives no
// result, every following byte gives one reconstructed byte on rsp_if, with
// line_end on the last byte of the line and bad_filter for types above four.
// Sustained rate is one byte per clock while rsp_if.ready holds. The rate is
// set by the left-byte loop, which closes through the pixel window registers
// of the back end, and by the single line store read per byte. The line
// store holds MAX_LINE_BYTES bytes and needs no clearing pass after reset: a
// fill mark makes unwritten positions read as zero. Configuration (index 0
// bytes per pixel, index 1 bytes per line) must be written by the user only
// while the block is idle; the block itself does not enforce this.
// Depends on psu_pkg, psu_req_if, psu_rsp_if, psu_front, psu_queue, psu_back.
`default_nettype none

module png_scanline_unfilter #(
   parameter int MAX_LINE_BYTES  = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [psu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [psu_pkg::CSR_DATA_W-1:0]  csr_write_data,
   psu_req_if.sink                              req_if,
   psu_rsp_if.source                            rsp_if
);

   localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
   localparam int OP_W  = $bits(psu_pkg::op_type);
   localparam int QW    = POS_W + OP_W;

   logic              q_push;
   logic              q_ready;
   psu_pkg::op_type   q_op;
   logic [POS_W-1:0]  q_pos;
   logic              q_pop;
   logic              q_head_valid;
   logic [QW-1:0]     q_head_data;
   psu_pkg::op_type   head_op;
   logic [POS_W-1:0]  head_pos;

   assign head_op  = psu_pkg::op_type'(q_head_data[OP_W-1:0]);
   assign head_pos = q_head_data[QW-1:OP_W];

   psu_front #(
      .MAX_LINE_BYTES  (MAX_LINE_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req_if),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_op             (q_op),
      .q_pos            (q_pos)
   );

   psu_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({q_pos, q_op}),
      .ready      (q_ready),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   psu_back #(
      .MAX_LINE_BYTES  (MAX_LINE_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_op    (head_op),
      .head_pos   (head_pos),
      .pop        (q_pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

[rtl/psu_checker.sv]
// Port-level checks of the PNG scanline unfilter, bound to the top level.
// Depends on png_scanline_unfilter_defines.svh and png_scanline_unfilter.
`default_nettype none
`include "png_scanline_unfilter_defines.svh"

module psu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_pixel_byte,
   input wire logic       rsp_line_end,
   input wire logic       rsp_bad_filter
);

   logic [9:0] rsp_word;

   assign rsp_word = {rsp_pixel_byte, rsp_line_end, rsp_bad_filter};

   // a waiting result stays offered
   `PSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // and keeps its word
   `PSU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_word))
   // nothing comes out right after reset
   `PSU_ASSERT_IMPLY(a_rsp_reset, clock, reset, $past(reset), !rsp_valid)
   // input back-pressure only follows a stalled result
   `PSU_ASSERT_IMPLY(a_req_stall, clock, reset, !req_ready && !$past(reset), $past(rsp_valid && !rsp_ready))

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_pixel_byte (rsp_if.pixel_byte),
   .rsp_line_end   (rsp_if.line_end),
   .rsp_bad_filter (rsp_if.bad_filter)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for the PNG scanline unfilter: directed rows, then random lines.
// Predicts each reconstructed byte in a local line-store model, or takes it from a directed row, and compares in order.
// Depends on psu_pkg, psu_req_if, psu_rsp_if and png_scanline_unfilter.
`timescale 1ns / 1ps

module testbench;

   localparam int LINE_STORE_BYTES = 8192;
   localparam int PIXEL_WINDOW     = 8;
   localparam int RANDOM_ITEMS     = 1500;
   localparam int LONG_ITEMS       = 300;
   localparam int MAX_GAP          = 13;
   localparam int SETTLE_CYCLES    = 4;
   localparam int FINAL_CYCLES     = 8;
   localparam int MAX_REPORTS      = 10;
   localparam longint CYCLE_LIMIT  = 1_000_000;

   localparam logic [psu_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [psu_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct packed {
      logic [psu_pkg::DATA_W-1:0] pixel;
      logic                       line_end;
      logic                       bad_filter;
   } pix_result_type;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [psu_pkg::CSR_INDEX_W-1:0] reg_index;
      logic [psu_pkg::CSR_DATA_W-1:0]  reg_value;
      logic [psu_pkg::DATA_W-1:0]      data;
      logic                            start;
      logic                            typed;
      pix_result_type                  want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [psu_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [psu_pkg::CSR_DATA_W-1:0]  csr_write_data;

   psu_req_if req();
   psu_rsp_if rsp();

   png_scanline_unfilter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req),
      .rsp_if           (rsp)
   );

   // Unfilter model state
   logic [psu_pkg::DATA_W-1:0]      line_store [LINE_STORE_BYTES];
   logic [psu_pkg::DATA_W-1:0]      left_win [PIXEL_WINDOW];
   logic [psu_pkg::DATA_W-1:0]      upleft_win [PIXEL_WINDOW];
   int                              line_pos;
   psu_pkg::filter_code_type        cur_filter;
   bit                              awaiting_type;
   bit                              top_row;
   logic [psu_pkg::CSR_PIXEL_W-1:0] cfg_pixel;
   logic [psu_pkg::CSR_LINE_W-1:0]  cfg_line;

   pix_result_type pending_pixels [$];
   stim_row_type   dir_rows [$];
   int             mismatch_count;
   longint         cycle_count;
   bit             tx_idle_on;
   bit             rx_idle_on;
   pix_result_type got_word;
   pix_result_type want_word;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [psu_pkg::DATA_W-1:0] paeth_pick(
      input logic [psu_pkg::DATA_W-1:0] a,
      input logic [psu_pkg::DATA_W-1:0] b,
      input logic [psu_pkg::DATA_W-1:0] c);
      int p;
      int da;
      int db;
      int dc;
      p  = int'(a) + int'(b) - int'(c);
      da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
      db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
      dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   task automatic clear_model();
      for (int i = 0; i < LINE_STORE_BYTES; i++) line_store[i] = '0;
      for (int i = 0; i < PIXEL_WINDOW; i++) begin
         left_win[i]   = '0;
         upleft_win[i] = '0;
      end
      line_pos      = 0;
      cur_filter    = psu_pkg::FILTER_NONE;
      awaiting_type = 1'b1;
      top_row       = 1'b1;
      cfg_pixel     = 4'd1;
      cfg_line      = 14'd1;
   endtask

   // Advance the model by one accepted word; a filter type word gives no result.
   task automatic unfilter_step(input logic [psu_pkg::DATA_W-1:0] data, input bit start_img,
                                output bit produced, output pix_result_type res);
      int pix_n;
      int len_n;
      int pos;
      int slot;
      logic [psu_pkg::DATA_W-1:0] a;
      logic [psu_pkg::DATA_W-1:0] b;
      logic [psu_pkg::DATA_W-1:0] c;
      logic [psu_pkg::DATA_W-1:0] pred;
      logic [psu_pkg::DATA_W:0]   avg_sum;
      produced = 1'b0;
      res      = '0;
      if (start_img) begin
         top_row       = 1'b1;
         awaiting_type = 1'b1;
      end
      if (awaiting_type) begin
         cur_filter = (data > psu_pkg::FILTER_MAX_CODE) ? psu_pkg::FILTER_BAD
                                                        : psu_pkg::filter_code_type'(data[2:0]);
         for (int i = 0; i < PIXEL_WINDOW; i++) begin
            left_win[i]   = '0;
            upleft_win[i] = '0;
         end
         line_pos      = 0;
         awaiting_type = 1'b0;
      end else begin
         pix_n = (cfg_pixel == 0) ? 1 : ((cfg_pixel > PIXEL_WINDOW) ? PIXEL_WINDOW : cfg_pixel);
         len_n = (cfg_line == 0) ? 1 :
                 ((cfg_line > LINE_STORE_BYTES) ? LINE_STORE_BYTES : cfg_line);
         pos   = line_pos % LINE_STORE_BYTES;
         slot  = pos % pix_n;
         a     = left_win[slot];
         c     = upleft_win[slot];
         b     = top_row ? '0 : line_store[pos];
         case (cur_filter)
            psu_pkg::FILTER_SUB: pred = a;
            psu_pkg::FILTER_UP: pred = b;
            psu_pkg::FILTER_AVERAGE: begin
               avg_sum = {1'b0, a} + {1'b0, b};
               pred    = avg_sum[psu_pkg::DATA_W:1];
            end
            psu_pkg::FILTER_PAETH: pred = paeth_pick(a, b, c);
            default: pred = '0;
         endcase
         res.pixel        = data + pred;
         res.bad_filter   = (cur_filter == psu_pkg::FILTER_BAD);
         upleft_win[slot] = b;
         left_win[slot]   = res.pixel;
         line_store[pos]  = res.pixel;
         if (pos + 1 >= len_n) begin
            res.line_end  = 1'b1;
            line_pos      = 0;
            awaiting_type = 1'b1;
            top_row       = 1'b0;
         end else begin
            res.line_end = 1'b0;
            line_pos     = pos + 1;
         end
         produced = 1'b1;
      end
   endtask

   task automatic send_word(input logic [psu_pkg::DATA_W-1:0] data, input bit start_img,
                            input bit typed, input pix_result_type want);
      int gap;
      bit produced;
      pix_result_type res;
      gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.data_byte <= data;
      req.new_image <= start_img;
      do @(posedge clock); while (req.ready !== 1'b1);
      unfilter_step(data, start_img, produced, res);
      if (produced) pending_pixels.push_back(typed ? want : res);
   endtask

   // Hold off until every expected word has come, then let the pipe settle.
   task automatic wait_drained(input int settle);
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [psu_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [psu_pkg::CSR_DATA_W-1:0] value);
      wait_drained(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      if (idx == psu_pkg::CSR_BYTES_PER_PIXEL) cfg_pixel = value[psu_pkg::CSR_PIXEL_W-1:0];
      else if (idx == psu_pkg::CSR_BYTES_PER_LINE) cfg_line = value[psu_pkg::CSR_LINE_W-1:0];
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_type row_word(input logic [psu_pkg::DATA_W-1:0] data,
                                             input bit start_img);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_WORD;
      r.data  = data;
      r.start = start_img;
      return r;
   endfunction

   function automatic stim_row_type row_check(input logic [psu_pkg::DATA_W-1:0] data,
                                              input bit start_img,
                                              input pix_result_type want);
      stim_row_type r;
      r       = row_word(data, start_img);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_type row_reg(input logic [psu_pkg::CSR_INDEX_W-1:0] idx,
                                            input logic [psu_pkg::CSR_DATA_W-1:0] value);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_REG;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   // Mostly well-formed lines with random content; noise restarts the image mid-line.
   task automatic run_phase(input int budget, input bit clean_start, input bit noise_on);
      logic [psu_pkg::DATA_W-1:0] d;
      bit s;
      for (int i = 0; i < budget; i++) begin
         s = (clean_start && i == 0) ||
             (noise_on && (awaiting_type ? $urandom_range(0, 7) == 0
                                         : $urandom_range(0, 39) == 0));
         if (awaiting_type || s) begin
            d = psu_pkg::DATA_W'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 4)
                                                             : $urandom_range(5, 255));
         end else begin
            case ($urandom_range(0, 7))
               0: d = 8'h00;
               1: d = 8'hFF;
               default: d = psu_pkg::DATA_W'($urandom_range(0, 255));
            endcase
         end
         send_word(d, s, 1'b0, '0);
      end
   endtask

   // Result side: stall a random number of cycles before taking each word.
   initial begin
      int stall;
      rx_idle_on = 1'b1;
      forever begin
         stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (rsp.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         got_word = {rsp.pixel_byte, rsp.line_end, rsp.bad_filter};
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected word: pixel %h line_end %b bad_filter %b",
                        got_word.pixel, got_word.line_end, got_word.bad_filter);
         end else begin
            want_word = pending_pixels.pop_front();
            if (got_word !== want_word) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected pixel %h line_end %b bad_filter %b, got %h %b %b",
                           want_word.pixel, want_word.line_end, want_word.bad_filter,
                           got_word.pixel, got_word.line_end, got_word.bad_filter);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int random_items;
      int chunk;
      int phase;
      bit long_done;
      logic [psu_pkg::CSR_PIXEL_W-1:0] pix_val;
      logic [psu_pkg::CSR_LINE_W-1:0]  len_val;
      logic [psu_pkg::CSR_DATA_W-1:0]  pix_word;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= psu_pkg::CSR_BYTES_PER_PIXEL;
      csr_write_data   <= '0;
      req.valid        <= 1'b0;
      req.data_byte    <= '0;
      req.new_image    <= 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      tx_idle_on     = 1'b1;
      clear_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One-byte lines at reset settings, then three-byte lines for the predictors
      dir_rows.push_back(row_word({5'd0, psu_pkg::FILTER_NONE}, 1'b1));
      dir_rows.push_back(row_check(8'hFF, 1'b0, '{8'hFF, 1'b1, 1'b0}));
      dir_rows.push_back(row_word({5'd0, psu_pkg::FILTER_UP}, 1'b0));
      dir_rows.push_back(row_check(8'h01, 1'b0, '{8'h00, 1'b1, 1'b0}));
      dir_rows.push_back(row_word(8'hFF, 1'b0));
      dir_rows.push_back(row_check(8'hAB, 1'b0, '{8'hAB, 1'b1, 1'b1}));
      dir_rows.push_back(row_reg(psu_pkg::CSR_BYTES_PER_PIXEL, 14'd0));
      dir_rows.push_back(row_reg(psu_pkg::CSR_BYTES_PER_LINE, 14'd3));
      dir_rows.push_back(row_reg(CSR_SPARE_LOW, 14'h3FFF));
      dir_rows.push_back(row_word({5'd0, psu_pkg::FILTER_SUB}, 1'b0));
      dir_rows.push_back(row_word(8'h80, 1'b0));
      dir_rows.push_back(row_word(8'h90, 1'b0));
      dir_rows.push_back(row_word(8'h7F, 1'b0));
      dir_rows.push_back(row_word({5'd0, psu_pkg::FILTER_AVERAGE}, 1'b0));
      dir_rows.push_back(row_word(8'h01, 1'b0));
      dir_rows.push_back(row_word(8'hFE, 1'b0));
      dir_rows.push_back(row_word(8'h33, 1'b0));
      dir_rows.push_back(row_word({5'd0, psu_pkg::FILTER_PAETH}, 1'b0));
      dir_rows.push_back(row_word(8'h00, 1'b0));
      dir_rows.push_back(row_word(8'hC4, 1'b0));
      dir_rows.push_back(row_word(8'h5A, 1'b0));
      // Abandon a line halfway with a new image
      dir_rows.push_back(row_word({5'd0, psu_pkg::FILTER_UP}, 1'b0));
      dir_rows.push_back(row_word(8'h55, 1'b0));
      dir_rows.push_back(row_word({5'd0, psu_pkg::FILTER_UP}, 1'b1));
      dir_rows.push_back(row_word(8'h12, 1'b0));
      dir_rows.push_back(row_word(8'hED, 1'b0));
      dir_rows.push_back(row_word(8'h40, 1'b0));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
         else send_word(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);
      end

      random_items = 0;
      phase        = 0;
      long_done    = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         if (!long_done && random_items >= RANDOM_ITEMS / 2) begin
            // One long line; the oversized length saturates to the store size, so it runs on
            write_reg(psu_pkg::CSR_BYTES_PER_PIXEL, 14'd8);
            write_reg(psu_pkg::CSR_BYTES_PER_LINE, 14'h3FFF);
            run_phase(LONG_ITEMS, 1'b1, 1'b0);
            random_items += LONG_ITEMS;
            long_done = 1'b1;
         end else begin
            case (phase)
               0: begin
                  pix_val = 4'hF;
                  len_val = 14'd0;
               end
               1: begin
                  pix_val = 4'd8;
                  len_val = 14'd1;
               end
               default: begin
                  case ($urandom_range(0, 9))
                     0: pix_val = 4'd0;
                     1: pix_val = psu_pkg::CSR_PIXEL_W'($urandom_range(9, 15));
                     default: pix_val = psu_pkg::CSR_PIXEL_W'($urandom_range(1, 8));
                  endcase
                  case ($urandom_range(0, 9))
                     0: len_val = 14'd0;
                     1: len_val = 14'd1;
                     default: len_val = psu_pkg::CSR_LINE_W'($urandom_range(2, 24));
                  endcase
               end
            endcase
            // Upper data bits are dropped by the pixel-size register
            pix_word = {psu_pkg::CSR_DATA_W{1'b0}};
            if ($urandom_range(0, 3) == 0)
               pix_word = psu_pkg::CSR_DATA_W'($urandom_range(0, 16383));
            pix_word[psu_pkg::CSR_PIXEL_W-1:0] = pix_val;
            write_reg(psu_pkg::CSR_BYTES_PER_PIXEL, pix_word);
            write_reg(psu_pkg::CSR_BYTES_PER_LINE, len_val);
            if ($urandom_range(0, 3) == 0)
               write_reg(($urandom_range(0, 1) != 0) ? CSR_SPARE_HIGH : CSR_SPARE_LOW,
                         psu_pkg::CSR_DATA_W'($urandom_range(0, 16383)));
            chunk = $urandom_range(10, 150);
            random_items += chunk;
            run_phase(chunk, 1'b0, 1'b1);
            phase++;
         end
      end

      wait_drained(FINAL_CYCLES);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[png_scanline_unfilter.f]
+incdir+rtl
rtl/psu_pkg.sv
rtl/psu_req_if.sv
rtl/psu_rsp_if.sv
rtl/psu_front.sv
rtl/psu_queue.sv
rtl/psu_back.sv
rtl/png_scanline_unfilter.sv
rtl/psu_checker.sv
tb/testbench.sv
